// ===== sv/npc_pkg.sv =====
`default_nettype none
package npc_pkg;

	localparam int CH_W   = 8;
	localparam int IDX_W  = 8;
	localparam int DIST_W = 18;
	localparam int SQ_W   = 2 * CH_W;

	localparam logic [DIST_W-1:0] DIST_START = DIST_W'(3 * 256 * 256);
	localparam logic [IDX_W-1:0]  NO_MATCH   = 8'hFF;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_QUERY = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	// request travelling down the cell row
	typedef struct packed {
		logic              valid;
		logic              query;
		logic [CH_W-1:0]   qr;
		logic [CH_W-1:0]   qg;
		logic [CH_W-1:0]   qb;
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] best;
		logic [CH_W-1:0]   cr;
		logic [CH_W-1:0]   cg;
		logic [CH_W-1:0]   cb;
	} tok_t;

	// entry write broadcast to every cell
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [CH_W-1:0]  r;
		logic [CH_W-1:0]  g;
		logic [CH_W-1:0]  b;
		logic             usable;
	} wr_t;

endpackage
`default_nettype wire

// ===== sv/npc_cell.sv =====
`default_nettype none
module npc_cell #(
	parameter int CELL_INDEX = 0,
	parameter bit CANDIDATE  = 1'b1
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            advance,
	input  npc_pkg::wr_t   wr,
	input  npc_pkg::tok_t  tok_in,
	output npc_pkg::tok_t  tok_out
);
	import npc_pkg::*;

	logic [CH_W-1:0]   color_r_q, color_g_q, color_b_q;
	logic              usable_q;
	logic              tok_valid_q;
	tok_t              tok_q;
	tok_t              tok_next;
	logic [CH_W-1:0]   dr, dg, db;
	logic [SQ_W-1:0]   sr, sg, sb;
	logic [DIST_W-1:0] cand_dist;

	always_comb begin
		dr = (tok_in.qr > color_r_q) ? tok_in.qr - color_r_q : color_r_q - tok_in.qr;
		dg = (tok_in.qg > color_g_q) ? tok_in.qg - color_g_q : color_g_q - tok_in.qg;
		db = (tok_in.qb > color_b_q) ? tok_in.qb - color_b_q : color_b_q - tok_in.qb;
		sr = SQ_W'(dr) * SQ_W'(dr);
		sg = SQ_W'(dg) * SQ_W'(dg);
		sb = SQ_W'(db) * SQ_W'(db);
		cand_dist = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);

		tok_next = tok_in;
		if (tok_in.query) begin
			// strict less-than keeps the lowest index on a tie
			if (CANDIDATE && usable_q && (cand_dist < tok_in.best)) begin
				tok_next.best = cand_dist;
				tok_next.idx  = IDX_W'(CELL_INDEX);
				tok_next.cr   = color_r_q;
				tok_next.cg   = color_g_q;
				tok_next.cb   = color_b_q;
			end
		end else if (tok_in.idx == IDX_W'(CELL_INDEX)) begin
			tok_next.cr = color_r_q;
			tok_next.cg = color_g_q;
			tok_next.cb = color_b_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_q    <= 1'b0;
			tok_valid_q <= 1'b0;
		end else begin
			if (wr.en && (wr.idx == IDX_W'(CELL_INDEX))) begin
				usable_q <= wr.usable;
			end
			if (advance) begin
				tok_valid_q <= tok_in.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && (wr.idx == IDX_W'(CELL_INDEX))) begin
			color_r_q <= wr.r;
			color_g_q <= wr.g;
			color_b_q <= wr.b;
		end
		if (advance) begin
			tok_q <= tok_next;
		end
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = tok_valid_q;
	end

endmodule
`default_nettype wire

// ===== sv/nearest_palette_color_top.sv =====
`default_nettype none
// Channel  Dir  Width  Fields (low bit first)
// s        in   40/2   tdata: entry_index, in_red, in_green, in_blue, entry_usable; tuser: kind
// m        out  32     tdata: color_index, out_red, out_green, out_blue
//
// A write gives no result. A query or read walks the row of PALETTE_ENTRIES cells, one
// cell per cycle unless the row is held, and its result is registered in the output
// register as it leaves the row; the cell row holds one request at a time, so no new
// request is taken until the last one has left the row. Reset clears the usable flags;
// entry colors stay undefined until written. A stalled result holds in the output
// register and the next request is taken meanwhile; it waits at the row end if needed.
module nearest_palette_color_top #(
	parameter int PALETTE_ENTRIES = 256,
	parameter int DROPPED_BITS    = 2
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,  // entry_index, in_red, in_green, in_blue, entry_usable
	input  wire  [1:0]  s_tuser,  // kind
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata   // color_index, out_red, out_green, out_blue
);
	import npc_pkg::*;

	localparam logic [CH_W-1:0] CH_MASK = CH_W'({CH_W{1'b1}} << DROPPED_BITS);

	logic            accept;
	logic            busy_q;
	logic            advance;
	logic            m_valid_q;
	logic [31:0]     m_data_q;
	wr_t             wr;
	tok_t            inject;
	tok_t            tok_chain [PALETTE_ENTRIES+1];
	tok_t            tail;
	logic [CH_W-1:0] in_r, in_g, in_b;
	logic [IDX_W-1:0] in_idx;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !busy_q;
	assign in_idx   = s_tdata[7:0];
	assign in_r     = s_tdata[15:8];
	assign in_g     = s_tdata[23:16];
	assign in_b     = s_tdata[31:24];

	always_comb begin
		wr.en     = 1'b0;
		wr.idx    = in_idx;
		wr.r      = in_r;
		wr.g      = in_g;
		wr.b      = in_b;
		wr.usable = s_tdata[32];

		inject.valid = 1'b0;
		inject.query = 1'b0;
		inject.qr    = in_r & CH_MASK;
		inject.qg    = in_g & CH_MASK;
		inject.qb    = in_b & CH_MASK;
		inject.idx   = in_idx;
		inject.best  = DIST_START;
		inject.cr    = '0;
		inject.cg    = '0;
		inject.cb    = '0;

		case (kind_t'(s_tuser))
			KIND_WRITE: begin
				wr.en = accept;
			end
			KIND_QUERY: begin
				inject.valid = accept;
				inject.query = 1'b1;
				inject.idx   = NO_MATCH;
			end
			KIND_READ: begin
				inject.valid = accept;
			end
			default: begin
				// unused kind: drop
			end
		endcase
	end

	assign tok_chain[0] = inject;
	assign tail         = tok_chain[PALETTE_ENTRIES];
	// hold the row only while a finished request waits behind a full output
	assign advance      = !(tail.valid && m_valid_q && !m_tready);

	for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
		npc_cell #(
			.CELL_INDEX (i),
			.CANDIDATE  (i != PALETTE_ENTRIES - 1)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.wr      (wr),
			.tok_in  (tok_chain[i]),
			.tok_out (tok_chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (inject.valid) begin
				busy_q <= 1'b1;
			end else if (tail.valid && advance) begin
				busy_q <= 1'b0;
			end
			if (tail.valid && advance) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail.valid && advance) begin
			m_data_q <= {tail.cb, tail.cg, tail.cr, tail.idx};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
`default_nettype wire

// ===== tb/palette_result_checker.sv =====
// Watches both channels of the palette block, keeps its own copy of the palette,
// predicts the answer to every query and read, and compares in order.
module palette_result_checker #(
	parameter int PALETTE_ENTRIES = 256,
	parameter int DROPPED_BITS    = 2
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [39:0] s_tdata,  // entry_index, in_red, in_green, in_blue, entry_usable
	input  wire  [1:0]  s_tuser,  // kind
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [31:0] m_tdata,  // color_index, out_red, out_green, out_blue
	output int          mismatches,
	output int          pending
);
	import npc_pkg::*;

	localparam logic [CH_W-1:0] KEEP_MASK = CH_W'(8'hFF << DROPPED_BITS);

	typedef struct packed {
		logic [CH_W-1:0]  blue;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  red;
		logic [IDX_W-1:0] idx;
	} color_result_t;

	logic [3*CH_W-1:0] pal_rgb [PALETTE_ENTRIES];
	bit                pal_use [PALETTE_ENTRIES];
	color_result_t     expected_colors [$];

	task automatic report_mismatch(string what);
		$display("%0t mismatch: %s", $time, what);
		mismatches++;
	endtask

	// scan all entries but the last; strict less keeps the lower index on a tie
	function automatic logic [IDX_W-1:0] closest_entry(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
			logic [CH_W-1:0] b);
		int best_dist, best_at, dr, dg, db, d;
		best_dist = int'(DIST_START);
		best_at = int'(NO_MATCH);
		for (int i = 0; i < PALETTE_ENTRIES - 1; i++) begin
			if (pal_use[i]) begin
				dr = int'(r) - int'(pal_rgb[i][23:16]);
				dg = int'(g) - int'(pal_rgb[i][15:8]);
				db = int'(b) - int'(pal_rgb[i][7:0]);
				d = dr * dr + dg * dg + db * db;
				if (d < best_dist) begin
					best_dist = d;
					best_at = i;
					if (d == 0)
						break;
				end
			end
		end
		return IDX_W'(best_at);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		color_result_t   got, want;
		logic [IDX_W-1:0] idx, hit;
		logic [CH_W-1:0]  r, g, b;
		if (!arst_n) begin
			for (int i = 0; i < PALETTE_ENTRIES; i++) begin
				pal_rgb[i] = '0;
				pal_use[i] = 1'b0;
			end
			expected_colors.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_colors.size() == 0) begin
					report_mismatch($sformatf("result %h with nothing expected", m_tdata));
				end else begin
					want = expected_colors.pop_front();
					if (got.idx !== want.idx)
						report_mismatch($sformatf("color_index got %h expected %h",
							got.idx, want.idx));
					if (got.red !== want.red)
						report_mismatch($sformatf("out_red got %h expected %h",
							got.red, want.red));
					if (got.green !== want.green)
						report_mismatch($sformatf("out_green got %h expected %h",
							got.green, want.green));
					if (got.blue !== want.blue)
						report_mismatch($sformatf("out_blue got %h expected %h",
							got.blue, want.blue));
				end
			end
			if (s_tvalid && s_tready) begin
				idx = s_tdata[7:0];
				r = s_tdata[15:8];
				g = s_tdata[23:16];
				b = s_tdata[31:24];
				case (s_tuser)
					KIND_WRITE: begin
						if (idx < PALETTE_ENTRIES) begin
							pal_rgb[idx] = {r, g, b};
							pal_use[idx] = s_tdata[32];
						end
					end
					KIND_QUERY: begin
						hit = closest_entry(r & KEEP_MASK, g & KEEP_MASK, b & KEEP_MASK);
						want.idx = hit;
						{want.red, want.green, want.blue} =
							(hit != NO_MATCH && hit < PALETTE_ENTRIES) ? pal_rgb[hit] : '0;
						expected_colors.push_back(want);
					end
					KIND_READ: begin
						want.idx = idx;
						{want.red, want.green, want.blue} =
							(idx < PALETTE_ENTRIES) ? pal_rgb[idx] : '0;
						expected_colors.push_back(want);
					end
					default: ;  // unused kind: drop
				endcase
			end
			pending <= expected_colors.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Drives writes, queries, reads and unused kinds into the palette block with random
// gaps and output stalls; the checker beside the block predicts and compares.
module tb_top;
	import npc_pkg::*;

	localparam int          ENTRIES     = 256;
	localparam int          DROP        = 2;
	localparam int          RANDOM_ITEMS = 1250;
	localparam int unsigned LIMIT       = 1_500_000;
	localparam logic [1:0]  KIND_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;  // entry_index, in_red, in_green, in_blue, entry_usable
	logic [1:0]  s_tuser = '0;  // kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;       // color_index, out_red, out_green, out_blue

	int          mismatches;
	int          pending;
	logic        steady = 1'b0;
	int unsigned cycle_count = 0;

	// entries written so far, so that reads never touch an undefined color
	bit          known [ENTRIES];
	logic [23:0] known_rgb [ENTRIES];
	int          known_list [$];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	nearest_palette_color_top #(
		.PALETTE_ENTRIES(ENTRIES),
		.DROPPED_BITS(DROP)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	palette_result_checker #(
		.PALETTE_ENTRIES(ENTRIES),
		.DROPPED_BITS(DROP)
	) i_color_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.mismatches(mismatches),
		.pending(pending)
	);

	// stall the result side for a random count after each accepted result
	always @(posedge clk or negedge arst_n) begin : result_pacing
		int hold, nxt;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold = 0;
		end else begin
			if (m_tvalid && m_tready)
				nxt = steady ? 0 : $urandom_range(0, 6);
			else
				nxt = (hold > 0) ? hold - 1 : 0;
			hold = nxt;
			m_tready <= (nxt == 0);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_request(logic [1:0] kind, logic [7:0] idx, logic [23:0] rgb,
			logic usable);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {7'd0, usable, rgb[7:0], rgb[15:8], rgb[23:16], idx};
		do @(posedge clk); while (!s_tready);
		if (kind == KIND_WRITE && idx < ENTRIES) begin
			if (!known[idx])
				known_list.push_back(int'(idx));
			known[idx] = 1'b1;
			known_rgb[idx] = rgb;
		end
	endtask

	// hold off the sender until every outstanding result is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_channel();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 7) * 32);
			1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] nudge(logic [7:0] c);
		int v;
		v = int'(c) + int'($urandom_range(0, 12)) - 6;
		return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
	endfunction

	initial begin
		int          sel, at;
		logic [23:0] c;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty palette, unused kind, last entry never chosen
		send_request(KIND_QUERY, 8'h00, 24'h123456, 1'b0);
		send_request(KIND_UNUSED, 8'h5A, 24'h987654, 1'b1);
		send_request(KIND_WRITE, 8'hFF, 24'hFFFFFF, 1'b1);
		send_request(KIND_QUERY, 8'hFF, 24'hFFFFFF, 1'b1);
		// only usable entries count; low bits of the query are dropped
		send_request(KIND_WRITE, 8'h00, 24'h000000, 1'b1);
		send_request(KIND_WRITE, 8'h01, 24'hFFFFFF, 1'b0);
		send_request(KIND_QUERY, 8'h00, 24'hFFFFFF, 1'b0);
		send_request(KIND_WRITE, 8'h02, 24'hFCFCFC, 1'b1);
		send_request(KIND_QUERY, 8'h00, 24'hFFFFFF, 1'b0);
		// equal distance goes to the lower index; duplicate exact match too
		send_request(KIND_WRITE, 8'h05, 24'h080000, 1'b1);
		send_request(KIND_WRITE, 8'h03, 24'h080808, 1'b1);
		send_request(KIND_QUERY, 8'h00, 24'h040000, 1'b0);
		send_request(KIND_WRITE, 8'h06, 24'h000000, 1'b1);
		send_request(KIND_QUERY, 8'hFF, 24'h000000, 1'b1);
		send_request(KIND_READ, 8'h00, 24'hFFFFFF, 1'b1);
		send_request(KIND_READ, 8'hFF, 24'h000000, 1'b0);
		send_request(KIND_READ, 8'h01, 24'h000000, 1'b0);
		send_request(KIND_READ, 8'h02, 24'h000000, 1'b0);
		send_request(KIND_WRITE, 8'h00, 24'h000000, 1'b0);
		send_request(KIND_QUERY, 8'h00, 24'h030303, 1'b0);
		send_request(KIND_WRITE, 8'h80, 24'hA55A3C, 1'b1);
		send_request(KIND_READ, 8'h80, 24'h5AA5C3, 1'b1);
		send_request(KIND_WRITE, 8'hFE, 24'h010203, 1'b1);
		send_request(KIND_UNUSED, 8'hFF, 24'hFFFFFF, 1'b1);
		drain_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 99)
				steady <= ($urandom_range(0, 2) == 0);
			if (n % 400 == 200)
				drain_results();
			sel = $urandom_range(0, 99);
			if (sel < 40 || known_list.size() == 0) begin
				send_request(KIND_WRITE, 8'($urandom_range(0, 255)),
					{pick_channel(), pick_channel(), pick_channel()},
					$urandom_range(0, 3) != 0);
			end else if (sel < 55) begin
				send_request(KIND_QUERY, 8'($urandom_range(0, 255)),
					{pick_channel(), pick_channel(), pick_channel()},
					1'($urandom_range(0, 1)));
			end else if (sel < 72) begin
				// land near a stored color to provoke close calls and ties
				at = known_list[$urandom_range(0, known_list.size() - 1)];
				c = known_rgb[at];
				send_request(KIND_QUERY, 8'($urandom_range(0, 255)),
					{nudge(c[23:16]), nudge(c[15:8]), nudge(c[7:0])},
					1'($urandom_range(0, 1)));
			end else if (sel < 95) begin
				at = known_list[$urandom_range(0, known_list.size() - 1)];
				send_request(KIND_READ, 8'(at), 24'($urandom()),
					1'($urandom_range(0, 1)));
			end else begin
				send_request(KIND_UNUSED, 8'($urandom_range(0, 255)), 24'($urandom()),
					1'($urandom_range(0, 1)));
			end
		end

		drain_results();
		repeat (ENTRIES + 8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
